FILE: src/seven_segment_scan_driver_defines.svh
// ---------------------------------------------------------------------------
// Seven-segment scan driver assertion macros
// Shared concurrent assertion helpers for the scan driver RTL.
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssd assertion failed");

// next-cycle implication, disabled in reset
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssd assertion failed");

`endif

FILE: src/ssd_pkg.sv
// ---------------------------------------------------------------------------
// Seven-segment scan driver package
// Sizes, operation codes, character encoding and the glyph segment table.
// ---------------------------------------------------------------------------
package ssd_pkg;

  localparam int NUM_DIGITS  = 8;
  localparam int DIGIT_W     = 3;
  localparam int CHAR_W      = 8;
  localparam int SEG_W       = 8;
  localparam int CODE_W      = 5;
  localparam int GLYPH_COUNT = 27;

  localparam logic [SEG_W-1:0]  SEG_BLANK  = 8'h00;
  localparam logic [CODE_W-1:0] CODE_BLANK = 5'd0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SCAN  = 1'b1
  } op_t;

  typedef struct packed {
    logic               en;
    logic [DIGIT_W-1:0] pos;
    logic [CHAR_W-1:0]  ch;
  } buf_wr_t;

  function automatic logic [CODE_W-1:0] char_to_code(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] diff;
    diff = '0;
    if (ch >= 8'd45 && ch <= 8'd58) begin
      diff = ch - 8'd44;
    end else if (ch >= 8'd65 && ch <= 8'd76) begin
      diff = ch - 8'd50;
    end
    return diff[CODE_W-1:0];
  endfunction

  function automatic logic [SEG_W-1:0] glyph_seg(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      5'd1:    seg = 8'h02;  // -
      5'd2:    seg = 8'h01;  // .
      5'd4:    seg = 8'hfc;  // 0
      5'd5:    seg = 8'h60;
      5'd6:    seg = 8'hda;
      5'd7:    seg = 8'hf2;
      5'd8:    seg = 8'h66;
      5'd9:    seg = 8'hb6;
      5'd10:   seg = 8'hbe;
      5'd11:   seg = 8'he0;
      5'd12:   seg = 8'hfe;
      5'd13:   seg = 8'hf6;  // 9
      5'd14:   seg = 8'h0c;  // :
      5'd15:   seg = 8'hee;  // A
      5'd17:   seg = 8'h9c;  // C
      5'd18:   seg = 8'hfc;  // D
      5'd19:   seg = 8'h9e;
      5'd20:   seg = 8'hce;  // F
      5'd22:   seg = 8'h6e;  // H
      5'd23:   seg = 8'h0c;
      5'd24:   seg = 8'h70;  // J
      5'd26:   seg = 8'h1c;  // L
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

FILE: src/ssd_glyph_buf.sv
// ---------------------------------------------------------------------------
// Seven-segment glyph buffer
// Per-digit glyph code storage with character encoding on write and
// segment pattern lookup on read.
// ---------------------------------------------------------------------------
module ssd_glyph_buf
  import ssd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  buf_wr_t            wr,
  input  logic [DIGIT_W-1:0] rd_idx,
  output logic [SEG_W-1:0]   rd_seg
);

  logic [CODE_W-1:0] buf_r [NUM_DIGITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        buf_r[i] <= CODE_BLANK;
      end
    end else if (wr.en) begin
      buf_r[wr.pos] <= char_to_code(wr.ch);
    end
  end

  assign rd_seg = glyph_seg(buf_r[rd_idx]);

endmodule

FILE: src/seven_segment_scan_driver.sv
// Order: a transaction is registered on acceptance and processed from there;
//   a scan tick loads its pattern, then its blank, into the output register.
// Throughput: one write per cycle while no stalled scan holds the input register; a scan
//   tick waits until the previous blank is loaded into the output register.
// Reset: synchronous active-low; clears the digit buffer to blank, scan index to 0,
//   and empties the input and output registers.
// ---------------------------------------------------------------------------
// Seven-segment scan driver
// Buffers ASCII characters per digit and emits segment pattern plus ghost
// blank for the current digit on each scan tick.
// ---------------------------------------------------------------------------
`include "seven_segment_scan_driver_defines.svh"

module seven_segment_scan_driver
  import ssd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [DIGIT_W-1:0] in_position,
  input  logic [CHAR_W-1:0]  in_character,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SEG_W-1:0]   out_segments,
  output logic [DIGIT_W-1:0] out_digit_select,
  output logic               out_blanking,
  output logic               out_last
);

  logic               inq_valid_r;
  op_t                inq_op_r;
  logic [DIGIT_W-1:0] inq_pos_r;
  logic [CHAR_W-1:0]  inq_char_r;

  logic               out_valid_r;
  logic [SEG_W-1:0]   out_seg_r;
  logic [DIGIT_W-1:0] out_digit_r;
  logic               out_blank_r;

  logic               blank_pend_r;
  logic [DIGIT_W-1:0] scan_index_r;
  logic [DIGIT_W-1:0] scan_index_nxt;

  logic               out_free;
  logic               write_go;
  logic               scan_go;
  logic               consume;
  buf_wr_t            buf_wr;
  logic [SEG_W-1:0]   rd_seg;

  assign out_free = !out_valid_r || out_ready;
  assign write_go = inq_valid_r && (inq_op_r == OP_WRITE);
  assign scan_go  = inq_valid_r && (inq_op_r == OP_SCAN) && out_free && !blank_pend_r;
  assign consume  = write_go || scan_go;
  assign in_ready = !inq_valid_r || consume;

  assign buf_wr.en  = write_go && (32'(inq_pos_r) < NUM_DIGITS);
  assign buf_wr.pos = inq_pos_r;
  assign buf_wr.ch  = inq_char_r;

  assign scan_index_nxt = (32'(scan_index_r) == NUM_DIGITS - 1) ? '0
                        : scan_index_r + DIGIT_W'(1);

  ssd_glyph_buf u_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (buf_wr),
    .rd_idx (scan_index_r),
    .rd_seg (rd_seg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_op_r   <= op_t'(in_operation);
      inq_pos_r  <= in_position;
      inq_char_r <= in_character;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      blank_pend_r <= 1'b0;
      scan_index_r <= '0;
    end else begin
      if (out_free && blank_pend_r) begin
        out_valid_r  <= 1'b1;
        blank_pend_r <= 1'b0;
      end else if (scan_go) begin
        out_valid_r  <= 1'b1;
        blank_pend_r <= 1'b1;
        scan_index_r <= scan_index_nxt;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && blank_pend_r) begin
      out_seg_r   <= SEG_BLANK;
      out_blank_r <= 1'b1;
    end else if (scan_go) begin
      out_seg_r   <= rd_seg;
      out_digit_r <= scan_index_r;
      out_blank_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = out_seg_r;
  assign out_digit_select = out_digit_r;
  assign out_blanking     = out_blank_r;
  assign out_last         = out_blank_r;

  `SSD_ASSERT_IMPL(a_pend_has_pattern, clk, rst_n, blank_pend_r, out_valid_r && !out_blank_r)
  `SSD_ASSERT_NEXT(a_blank_follows, clk, rst_n, out_valid && out_ready && !out_blanking,
                   out_valid && out_blanking && out_digit_select == $past(out_digit_select))
  `SSD_ASSERT_IMPL(a_scan_in_range, clk, rst_n, 1'b1, 32'(scan_index_r) < NUM_DIGITS)
  `SSD_ASSERT_NEXT(a_scan_sets_pend, clk, rst_n, scan_go, blank_pend_r && !out_blanking)

endmodule

FILE: bench/seven_segment_scan_driver_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Seven-segment scan driver testbench
// Sends character writes and scan ticks, with directed rows first, then
// random traffic under several sender/receiver idle mixes and one long
// receiver hold-off. Each accepted transaction updates a local display model
// whose predicted segment/blank pairs are matched in order against the output.
// ---------------------------------------------------------------------------
module seven_segment_scan_driver_tb;
  import ssd_pkg::*;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DIRECTED_ROWS   = 23;

  typedef struct {
    op_t                op;
    logic [DIGIT_W-1:0] pos;
    logic [CHAR_W-1:0]  ch;
    bit                 typed;
    logic [SEG_W-1:0]   seg;
    logic [DIGIT_W-1:0] digit;
  } stim_row_t;

  typedef struct {
    logic [SEG_W-1:0]   seg;
    logic [DIGIT_W-1:0] digit;
    logic               blanking;
    logic               last;
  } seg_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_operation;
  logic [DIGIT_W-1:0] in_position;
  logic [CHAR_W-1:0]  in_character;
  logic               out_valid;
  logic               out_ready;
  logic [SEG_W-1:0]   out_segments;
  logic [DIGIT_W-1:0] out_digit_select;
  logic               out_blanking;
  logic               out_last;

  logic [SEG_W-1:0] glyph_segs [GLYPH_COUNT] = '{
    8'h00,
    8'h02, 8'h01, 8'h00,
    8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66,
    8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6,
    8'h0c,
    8'hee, 8'h00, 8'h9c, 8'hfc, 8'h9e, 8'hce,
    8'h00, 8'h6e, 8'h0c, 8'h70, 8'h00, 8'h1c
  };

  // after reset: blank digits; typed rows carry the pattern of the scan tick
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_SCAN,  3'd7, 8'hff, 1'b1, 8'h00, 3'd0},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'h00, 3'd1},
    '{OP_WRITE, 3'd0, 8'h30, 1'b0, 8'h00, 3'd0},
    '{OP_WRITE, 3'd7, 8'd76, 1'b0, 8'h00, 3'd0},
    '{OP_WRITE, 3'd2, 8'd45, 1'b0, 8'h00, 3'd0},
    '{OP_WRITE, 3'd3, 8'd58, 1'b0, 8'h00, 3'd0},
    '{OP_WRITE, 3'd4, 8'd65, 1'b0, 8'h00, 3'd0},
    '{OP_WRITE, 3'd5, 8'hff, 1'b0, 8'h00, 3'd0},
    '{OP_WRITE, 3'd6, 8'd47, 1'b0, 8'h00, 3'd0},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'h02, 3'd2},
    '{OP_SCAN,  3'd5, 8'h41, 1'b1, 8'h0c, 3'd3},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'hee, 3'd4},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'h00, 3'd5},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'h00, 3'd6},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'h1c, 3'd7},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'hfc, 3'd0},
    '{OP_WRITE, 3'd1, 8'd44, 1'b0, 8'h00, 3'd0},
    '{OP_WRITE, 3'd2, 8'd77, 1'b0, 8'h00, 3'd0},
    '{OP_WRITE, 3'd3, 8'd75, 1'b0, 8'h00, 3'd0},
    '{OP_WRITE, 3'd0, 8'h00, 1'b0, 8'h00, 3'd0},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'h00, 3'd1},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'h00, 3'd2},
    '{OP_SCAN,  3'd0, 8'h00, 1'b1, 8'h00, 3'd3}
  };

  logic [CODE_W-1:0]  glyph_codes [8];
  logic [DIGIT_W-1:0] scan_digit;
  seg_result_t        expected_results [$];

  int   error_count = 0;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   idle_cycles = 0;
  logic hold_off    = 1'b0;

  seven_segment_scan_driver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_character     (in_character),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_select (out_digit_select),
    .out_blanking     (out_blanking),
    .out_last         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [CODE_W-1:0] code_of_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] offs;
    offs = '0;
    if (c >= 8'd45 && c <= 8'd58) begin
      offs = c - 8'd44;
    end else if (c >= 8'd65 && c <= 8'd76) begin
      offs = c - 8'd50;
    end
    return offs[CODE_W-1:0];
  endfunction

  task automatic update_display_model(input stim_row_t r);
    logic [DIGIT_W-1:0] d;
    seg_result_t        res;
    if (r.op == OP_WRITE) begin
      if (int'(r.pos) < NUM_DIGITS) glyph_codes[r.pos] = code_of_char(r.ch);
    end else begin
      d = (int'(scan_digit) < NUM_DIGITS) ? scan_digit : '0;
      res.seg      = r.typed ? r.seg : glyph_segs[glyph_codes[d]];
      res.digit    = r.typed ? r.digit : d;
      res.blanking = 1'b0;
      res.last     = 1'b0;
      expected_results.push_back(res);
      res.seg      = SEG_BLANK;
      res.digit    = d;
      res.blanking = 1'b1;
      res.last     = 1'b1;
      expected_results.push_back(res);
      scan_digit = (int'(d) + 1 >= NUM_DIGITS) ? '0 : d + 1'b1;
    end
  endtask

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_transaction(input stim_row_t r);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= r.op;
    in_position  <= r.pos;
    in_character <= r.ch;
    do @(posedge clk); while (!in_ready);
    update_display_model(r);
  endtask

  task automatic run_phase(input int count, input int in_idle, input int out_stall,
                           input bit pressure);
    stim_row_t r;
    idle_pct  = in_idle;
    stall_pct = out_stall;
    if (pressure) begin
      fork
        begin
          hold_off <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_off <= 1'b0;
        end
      join_none
    end
    for (int i = 0; i < count; i++) begin
      r.op    = ($urandom_range(0, 99) < 55) ? OP_SCAN : OP_WRITE;
      r.pos   = DIGIT_W'($urandom_range(0, 7));
      r.typed = 1'b0;
      r.seg   = '0;
      r.digit = '0;
      case ($urandom_range(0, 5))
        1: r.ch = CHAR_W'($urandom_range(45, 58));
        2: r.ch = CHAR_W'($urandom_range(65, 76));
        3: r.ch = $urandom_range(0, 1) ? 8'd44 : 8'd59;
        4: r.ch = $urandom_range(0, 1) ? 8'd64 : 8'd77;
        default: r.ch = CHAR_W'($urandom_range(0, 255));
      endcase
      send_transaction(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    seg_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual seg=%0h digit=%0d",
                 $time, out_segments, out_digit_select);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("segments", e.seg, out_segments);
        check_field("digit_select", 8'(e.digit), 8'(out_digit_select));
        check_field("blanking", 8'(e.blanking), 8'(out_blanking));
        check_field("last", 8'(e.last), 8'(out_last));
      end
    end
    out_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_WRITE;
    in_position  = '0;
    in_character = '0;
    out_ready    = 1'b0;
    for (int i = 0; i < 8; i++) glyph_codes[i] = CODE_BLANK;
    scan_digit = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) send_transaction(directed_rows[i]);

    run_phase(110, 0, 0, 1'b1);
    run_phase(110, 46, 0, 1'b0);
    run_phase(110, 0, 46, 1'b0);
    run_phase(110, 22, 22, 1'b0);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
